@@ rtl/ccs_pkg.sv @@
// ccs_pkg: shared widths, constants and controller/datapath interface types
// for the min/max contrast stretch block. No dependencies.

package ccs_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int NUM_LANES   = 3;
    localparam int CNT_BITS    = $clog2(SAMPLE_BITS);

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [CNT_BITS-1:0]    t_cnt;

    localparam t_sample FULL_SCALE = {SAMPLE_BITS{1'b1}};
    localparam t_cnt    LAST_STEP  = t_cnt'(SAMPLE_BITS - 1);

    typedef struct packed {
        logic measure;   // fold accepted measure transaction into min/max
        logic load;      // start stretch of accepted apply transaction
        logic step;      // one quotient bit per lane
        logic out_load;  // move finished result into output register
    } t_ctl_cmd;

    typedef struct packed {
        logic out_free;  // output register empty or being taken this cycle
    } t_dp_sts;

endpackage

@@ rtl/ccs_ctrl.sv @@
// ccs_ctrl: controller state machine for the contrast stretch block.
// Depends on ccs_pkg.

module ccs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_cmd,
    input  ccs_pkg::t_dp_sts  i_sts,
    output logic              o_in_stall,
    output ccs_pkg::t_ctl_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

    t_state        r_state;
    ccs_pkg::t_cnt r_cnt;
    logic          accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        o_cmd          = '0;
        o_cmd.measure  = accept && !i_cmd;
        o_cmd.load     = accept && i_cmd;
        o_cmd.step     = (r_state == S_DIV);
        o_cmd.out_load = (r_state == S_DONE) && i_sts.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (accept && i_cmd) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == ccs_pkg::LAST_STEP) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/ccs_datapath.sv @@
// ccs_datapath: min/max marks, three bit-serial restoring divider lanes,
// color mode register and output register. Depends on ccs_pkg.

module ccs_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ccs_pkg::t_ctl_cmd i_cmd,
    output ccs_pkg::t_dp_sts  o_sts,
    input  logic              i_cfg_we,
    input  logic              i_cfg_data,
    input  logic              i_first_of_frame,
    input  ccs_pkg::t_sample  i_red,
    input  ccs_pkg::t_sample  i_green,
    input  ccs_pkg::t_sample  i_blue,
    input  ccs_pkg::t_sample  i_alpha,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output ccs_pkg::t_sample  o_out_red,
    output ccs_pkg::t_sample  o_out_green,
    output ccs_pkg::t_sample  o_out_blue,
    output ccs_pkg::t_sample  o_out_alpha
);

    localparam int SB = ccs_pkg::SAMPLE_BITS;
    localparam int NL = ccs_pkg::NUM_LANES;

    logic             r_color_mode;
    ccs_pkg::t_sample r_low;
    ccs_pkg::t_sample r_high;
    ccs_pkg::t_sample n_low;
    ccs_pkg::t_sample n_high;
    ccs_pkg::t_sample r_span;
    ccs_pkg::t_sample r_alpha;
    logic             r_color_item;
    logic             r_out_valid;
    ccs_pkg::t_sample r_out_red;
    ccs_pkg::t_sample r_out_green;
    ccs_pkg::t_sample r_out_blue;
    ccs_pkg::t_sample r_out_alpha;
    ccs_pkg::t_sample samples [NL];
    ccs_pkg::t_sample r_quo   [NL];
    ccs_pkg::t_sample r_rem   [NL];
    logic             r_fix   [NL];
    logic             flat;

    assign samples[0] = i_red;
    assign samples[1] = i_green;
    assign samples[2] = i_blue;
    assign flat       = (r_high <= r_low);

    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    // min/max fold
    always_comb begin
        n_low  = i_first_of_frame ? ccs_pkg::FULL_SCALE : r_low;
        n_high = i_first_of_frame ? '0 : r_high;
        for (int k = 0; k < NL; k++) begin
            if (k == 0 || r_color_mode) begin
                if (samples[k] < n_low) begin
                    n_low = samples[k];
                end
                if (samples[k] > n_high) begin
                    n_high = samples[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_mode <= 1'b0;
            r_low        <= ccs_pkg::FULL_SCALE;
            r_high       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_color_mode <= i_cfg_data;
            end
            if (i_cmd.measure) begin
                r_low  <= n_low;
                r_high <= n_high;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_span       <= r_high - r_low;
            r_alpha      <= i_alpha;
            r_color_item <= r_color_mode;
        end
        if (i_cmd.out_load) begin
            r_out_red   <= r_quo[0];
            r_out_green <= r_color_item ? r_quo[1] : '0;
            r_out_blue  <= r_color_item ? r_quo[2] : '0;
            r_out_alpha <= r_color_item ? r_alpha  : '0;
        end
    end

    for (genvar g = 0; g < NL; g++) begin : g_lane
        logic [SB:0]   diff;
        logic [SB:0]   span_w;
        logic [2*SB-1:0] prod;
        logic [SB:0]   shifted;
        logic [SB:0]   trial;

        assign diff   = {1'b0, samples[g]} - {1'b0, r_low};
        assign span_w = {1'b0, r_high} - {1'b0, r_low};
        // d * (2^SB - 1) = (d << SB) - d
        assign prod   = {diff[SB-1:0], {SB{1'b0}}} - {{SB{1'b0}}, diff[SB-1:0]};
        assign shifted = {r_rem[g], r_quo[g][SB-1]};
        assign trial   = shifted - {1'b0, r_span};

        always_ff @(posedge i_clk) begin
            if (i_cmd.load) begin
                r_rem[g] <= '0;
                priority if (samples[g] <= r_low) begin
                    r_fix[g] <= 1'b1;
                    r_quo[g] <= '0;
                end else if (flat) begin
                    r_fix[g] <= 1'b1;
                    r_quo[g] <= diff[SB-1:0];
                end else if (diff > span_w) begin
                    r_fix[g] <= 1'b1;
                    r_quo[g] <= ccs_pkg::FULL_SCALE;
                end else begin
                    r_fix[g] <= 1'b0;
                    r_rem[g] <= prod[2*SB-1:SB];
                    r_quo[g] <= prod[SB-1:0];
                end
            end else if (i_cmd.step && !r_fix[g]) begin
                if (!trial[SB]) begin
                    r_rem[g] <= trial[SB-1:0];
                    r_quo[g] <= {r_quo[g][SB-2:0], 1'b1};
                end else begin
                    r_rem[g] <= shifted[SB-1:0];
                    r_quo[g] <= {r_quo[g][SB-2:0], 1'b0};
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_red   = r_out_red;
    assign o_out_green = r_out_green;
    assign o_out_blue  = r_out_blue;
    assign o_out_alpha = r_out_alpha;

endmodule

@@ rtl/contrast_stretch_minmax.sv @@
// contrast_stretch_minmax: top level, min/max contrast stretch over 16-bit samples.
// Depends on ccs_pkg, ccs_ctrl and ccs_datapath.
//
// Usage: the host streams each frame twice over the input channel
// (i_in_valid / o_in_stall). Measure transactions (i_cmd 0) fold red, or red,
// green and blue in color mode, into a running min/max; i_first_of_frame
// restarts the pair. Apply transactions (i_cmd 1) return one stretched pixel
// on the output channel (o_out_valid / i_out_stall).
// A measure transaction is folded in at its accepting edge. An apply transaction
// loads the three bit-serial restoring divider lanes at its accepting edge, runs
// them one quotient bit per cycle until every quotient bit is done, then moves the
// result into the output register once that register is free; only then is the
// next transaction accepted.
// The input is free again once the result is registered, so a held result
// never blocks measure work or the next apply computation; a second finished
// result waits, with the input stalled, while the receiver stalls.
// The color mode register is written over i_cfg_valid / o_cfg_ready (always ready);
// the user must write it only while the block is idle, which the block does not enforce.
// Synchronous reset (i_rst_n low) clears the marks to min full scale and
// max zero, selects gray mode and empties the output register.

module contrast_stretch_minmax (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_cmd,
    input  logic             i_first_of_frame,
    input  ccs_pkg::t_sample i_red,
    input  ccs_pkg::t_sample i_green,
    input  ccs_pkg::t_sample i_blue,
    input  ccs_pkg::t_sample i_alpha,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output ccs_pkg::t_sample o_out_red,
    output ccs_pkg::t_sample o_out_green,
    output ccs_pkg::t_sample o_out_blue,
    output ccs_pkg::t_sample o_out_alpha
);

    ccs_pkg::t_ctl_cmd cmd;
    ccs_pkg::t_dp_sts  sts;

    assign o_cfg_ready = 1'b1;

    ccs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    ccs_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_first_of_frame (i_first_of_frame),
        .i_red            (i_red),
        .i_green          (i_green),
        .i_blue           (i_blue),
        .i_alpha          (i_alpha),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_out_red        (o_out_red),
        .o_out_green      (o_out_green),
        .o_out_blue       (o_out_blue),
        .o_out_alpha      (o_out_alpha)
    );

endmodule
